### src/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

   // Extra bits on the error term above the coordinate width. They cover the
   // sign and the +/- range that the term swings through between steps.
   localparam int ERR_MARGIN = 3;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   typedef struct packed {
      logic move_x;
      logic move_y;
      logic last;
   } step_ctrl_type;

endpackage

`default_nettype wire

### src/mlr_step.sv
`default_nettype none

module mlr_step import mlr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]            cur_x,
   input  logic [COORD_BITS-1:0]            cur_y,
   input  logic [COORD_BITS-1:0]            goal_x,
   input  logic [COORD_BITS-1:0]            goal_y,
   input  logic signed [COORD_BITS+ERR_MARGIN-1:0] err,
   input  logic [COORD_BITS-1:0]            abs_dx,
   input  logic [COORD_BITS-1:0]            abs_dy,
   input  logic                             dir_x,
   input  logic                             dir_y,
   output logic [COORD_BITS-1:0]            next_x,
   output logic [COORD_BITS-1:0]            next_y,
   output logic signed [COORD_BITS+ERR_MARGIN-1:0] next_err,
   output step_ctrl_type                    ctrl
);

   localparam int ERR_W = COORD_BITS + ERR_MARGIN;

   logic signed [ERR_W:0]   e2;
   logic signed [ERR_W:0]   dx_wide;
   logic signed [ERR_W:0]   dy_wide;
   logic signed [ERR_W-1:0] dx_err;
   logic signed [ERR_W-1:0] dy_err;
   logic signed [ERR_W-1:0] sub_dy;
   logic signed [ERR_W-1:0] add_dx;

   assign e2      = {err, 1'b0};
   assign dx_wide = $signed({{(ERR_W + 1 - COORD_BITS){1'b0}}, abs_dx});
   assign dy_wide = $signed({{(ERR_W + 1 - COORD_BITS){1'b0}}, abs_dy});
   assign dx_err  = $signed({{(ERR_W - COORD_BITS){1'b0}}, abs_dx});
   assign dy_err  = $signed({{(ERR_W - COORD_BITS){1'b0}}, abs_dy});

   always_comb begin
      ctrl.last   = (cur_x == goal_x) && (cur_y == goal_y);
      // midpoint test on the doubled error: e2 >= -dy moves x, e2 <= dx moves y
      ctrl.move_x = !ctrl.last && ((e2 + dy_wide) >= $signed({(ERR_W + 1){1'b0}}));
      ctrl.move_y = !ctrl.last && (e2 <= dx_wide);

      sub_dy   = ctrl.move_x ? dy_err : '0;
      add_dx   = ctrl.move_y ? dx_err : '0;
      next_err = err - sub_dy + add_dx;

      next_x = cur_x;
      if (ctrl.move_x) begin
         next_x = dir_x ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      next_y = cur_y;
      if (ctrl.move_y) begin
         next_y = dir_y ? cur_y - 1'b1 : cur_y + 1'b1;
      end
   end

endmodule

`default_nettype wire

### src/midpoint_line_rasterizer_top.sv
`default_nettype none

// Channel   Dir  Handshake            Word
// req_      in   req_valid/req_stall  opcode, start/end point, line colour
// rsp_      out  rsp_valid/rsp_stall  pixel x/y, colour, last flag
//
// One word per cycle while req_stall is low: a step word yields its pixel,
// the line state, in the cycle after acceptance, and one error add and compare
// advance that state. A load word yields nothing and a step word with no line
// loaded is dropped. Reset clears the line state and the output valid; no line
// is active after it. req_stall is raised only while a pixel sits in the output
// register and rsp_stall holds it.
module midpoint_line_rasterizer_top import mlr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [31:0]           req_line_colour,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [31:0]           rsp_pixel_colour,
   output logic                  rsp_last_pixel
);

   localparam int ERR_W = COORD_BITS + ERR_MARGIN;

   logic [COORD_BITS-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]   goal_x_ff, goal_x_in;
   logic [COORD_BITS-1:0]   goal_y_ff, goal_y_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [COORD_BITS-1:0]   abs_dx_ff, abs_dx_in;
   logic [COORD_BITS-1:0]   abs_dy_ff, abs_dy_in;
   logic                    dir_x_ff, dir_x_in;
   logic                    dir_y_ff, dir_y_in;
   logic                    active_ff, active_in;
   logic [31:0]             colour_ff, colour_in;

   logic                    out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]   out_x_ff, out_x_in;
   logic [COORD_BITS-1:0]   out_y_ff, out_y_in;
   logic [31:0]             out_colour_ff, out_colour_in;
   logic                    out_last_ff, out_last_in;

   logic                    req_fire;
   logic                    is_load;
   logic                    emit;
   logic                    load_dir_x;
   logic                    load_dir_y;
   logic [COORD_BITS-1:0]   load_dx;
   logic [COORD_BITS-1:0]   load_dy;
   logic [COORD_BITS-1:0]   step_x;
   logic [COORD_BITS-1:0]   step_y;
   logic signed [ERR_W-1:0] step_err;
   step_ctrl_type           step_ctrl;

   assign req_stall = out_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign is_load   = (req_opcode == OP_LOAD);
   assign emit      = req_fire && !is_load && active_ff;

   assign load_dir_x = (req_end_x < req_start_x);
   assign load_dir_y = (req_end_y < req_start_y);
   assign load_dx    = load_dir_x ? req_start_x - req_end_x : req_end_x - req_start_x;
   assign load_dy    = load_dir_y ? req_start_y - req_end_y : req_end_y - req_start_y;

   mlr_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cur_x    (cur_x_ff),
      .cur_y    (cur_y_ff),
      .goal_x   (goal_x_ff),
      .goal_y   (goal_y_ff),
      .err      (err_ff),
      .abs_dx   (abs_dx_ff),
      .abs_dy   (abs_dy_ff),
      .dir_x    (dir_x_ff),
      .dir_y    (dir_y_ff),
      .next_x   (step_x),
      .next_y   (step_y),
      .next_err (step_err),
      .ctrl     (step_ctrl)
   );

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      err_in    = err_ff;
      abs_dx_in = abs_dx_ff;
      abs_dy_in = abs_dy_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      active_in = active_ff;
      colour_in = colour_ff;

      if (req_fire && is_load) begin
         // drop any line in progress
         cur_x_in  = req_start_x;
         cur_y_in  = req_start_y;
         goal_x_in = req_end_x;
         goal_y_in = req_end_y;
         abs_dx_in = load_dx;
         abs_dy_in = load_dy;
         dir_x_in  = load_dir_x;
         dir_y_in  = load_dir_y;
         err_in    = $signed({{(ERR_W - COORD_BITS){1'b0}}, load_dx})
                   - $signed({{(ERR_W - COORD_BITS){1'b0}}, load_dy});
         colour_in = req_line_colour;
         active_in = 1'b1;
      end else if (emit) begin
         cur_x_in  = step_x;
         cur_y_in  = step_y;
         err_in    = step_err;
         active_in = !step_ctrl.last;
      end
   end

   always_comb begin
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_colour_in = out_colour_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_x_in      = cur_x_ff;
         out_y_in      = cur_y_ff;
         out_colour_in = colour_ff;
         out_last_in   = step_ctrl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         err_ff       <= '0;
         abs_dx_ff    <= '0;
         abs_dy_ff    <= '0;
         dir_x_ff     <= 1'b0;
         dir_y_ff     <= 1'b0;
         active_ff    <= 1'b0;
         colour_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         err_ff       <= err_in;
         abs_dx_ff    <= abs_dx_in;
         abs_dy_ff    <= abs_dy_in;
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         active_ff    <= active_in;
         colour_ff    <= colour_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_colour_ff <= out_colour_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_colour = out_colour_ff;
   assign rsp_last_pixel   = out_last_ff;

   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_load && !active_ff |=> !rsp_valid)
      else $error("step with no line produced a pixel");

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_load |=> active_ff && !rsp_valid)
      else $error("load did not arm the line or produced a pixel");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |-> !active_ff)
      else $error("line still active after its last pixel");

   a_last_is_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |-> rsp_pixel_x == goal_x_ff && rsp_pixel_y == goal_y_ff)
      else $error("last pixel is not the line end point");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench import mlr_pkg::*;;

   localparam int COORD_W = 12;
   localparam int COORD_MAX = (1 << COORD_W) - 1;
   localparam int WORD_GOAL = 1750;
   // One word per cycle plus about 7% idling on each side; this leaves plenty of room
   localparam int CYCLE_LIMIT = 100000;

   typedef struct {
      opcode_type         op;
      bit [COORD_W-1:0]   sx;
      bit [COORD_W-1:0]   sy;
      bit [COORD_W-1:0]   ex;
      bit [COORD_W-1:0]   ey;
      bit [31:0]          colour;
      bit                 drain;
   } line_word_type;

   typedef struct {
      bit [COORD_W-1:0]   x;
      bit [COORD_W-1:0]   y;
      bit [31:0]          colour;
      bit                 is_end;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_LOAD;
   logic [COORD_W-1:0]   req_start_x = '0;
   logic [COORD_W-1:0]   req_start_y = '0;
   logic [COORD_W-1:0]   req_end_x = '0;
   logic [COORD_W-1:0]   req_end_y = '0;
   logic [31:0]          req_line_colour = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COORD_W-1:0]   rsp_pixel_x;
   logic [COORD_W-1:0]   rsp_pixel_y;
   logic [31:0]          rsp_pixel_colour;
   logic                 rsp_last_pixel;

   midpoint_line_rasterizer_top #(.COORD_BITS(COORD_W)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_line_colour  (req_line_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   line_word_type pending_words[$];
   pixel_type     expected_pixels[$];

   // Line walker state, mirrors the block
   bit [COORD_W-1:0] walk_x, walk_y, goal_x, goal_y;
   int               span_x, span_y, walk_err;
   bit               neg_x, neg_y, line_live;
   bit [31:0]        line_colour;

   bit  req_fire = 1'b0;
   int  word_total = 0;
   int  words_sent = 0;
   int  lines_loaded = 0;
   int  pixels_checked = 0;
   int  line_ends = 0;
   int  fault_count = 0;
   int  cycle_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void trace_line_word(input line_word_type w);
      pixel_type p;
      int        e2;
      if (w.op == OP_LOAD) begin
         walk_x = w.sx;
         walk_y = w.sy;
         goal_x = w.ex;
         goal_y = w.ey;
         span_x = (w.ex >= w.sx) ? int'(w.ex) - int'(w.sx) : int'(w.sx) - int'(w.ex);
         span_y = (w.ey >= w.sy) ? int'(w.ey) - int'(w.sy) : int'(w.sy) - int'(w.ey);
         neg_x = w.ex < w.sx;
         neg_y = w.ey < w.sy;
         walk_err = span_x - span_y;
         line_colour = w.colour;
         line_live = 1'b1;
         lines_loaded++;
      end else if (line_live) begin
         p.x = walk_x;
         p.y = walk_y;
         p.colour = line_colour;
         p.is_end = (walk_x == goal_x) && (walk_y == goal_y);
         expected_pixels.push_back(p);
         if (p.is_end) begin
            line_live = 1'b0;
         end else begin
            e2 = 2 * walk_err;
            if (e2 >= -span_y) begin
               walk_err -= span_y;
               walk_x = neg_x ? walk_x - 1'b1 : walk_x + 1'b1;
            end
            if (e2 <= span_x) begin
               walk_err += span_x;
               walk_y = neg_y ? walk_y - 1'b1 : walk_y + 1'b1;
            end
         end
      end
   endfunction

   task automatic add_word(input opcode_type op, input int sx, input int sy, input int ex,
                           input int ey, input bit [31:0] colour, input bit drain = 1'b0);
      line_word_type w;
      w.op = op;
      w.sx = sx[COORD_W-1:0];
      w.sy = sy[COORD_W-1:0];
      w.ex = ex[COORD_W-1:0];
      w.ey = ey[COORD_W-1:0];
      w.colour = colour;
      w.drain = drain;
      pending_words.push_back(w);
      word_total++;
   endtask

   // Step words carry junk in the load fields; the block must ignore it
   task automatic add_steps(input int count);
      repeat (count) begin
         add_word(OP_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom());
      end
   endtask

   function automatic int near_coord(input int base, input int span);
      int v;
      v = base + int'($urandom_range(2 * span)) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   // Request side: note accepted words and predict their pixels
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         trace_line_word(pending_words.pop_front());
         words_sent++;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_words.size() != 0
               && !(pending_words[0].drain && expected_pixels.size() != 0)
               && !(($urandom_range(99) < 7) && !(words_sent >= 500 && words_sent < 850)))
         begin
            req_valid <= 1'b1;
            req_opcode <= pending_words[0].op;
            req_start_x <= pending_words[0].sx;
            req_start_y <= pending_words[0].sy;
            req_end_x <= pending_words[0].ex;
            req_end_y <= pending_words[0].ey;
            req_line_colour <= pending_words[0].colour;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (pixels_checked >= 200 && pixels_checked < 450)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= $urandom_range(99) < 7;
   end

   always @(posedge clock) begin
      pixel_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending, %0d pixels owed",
                  cycle_count, pending_words.size(), expected_pixels.size());
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected pixel word x=%0d y=%0d colour=%h last=%0d",
                        rsp_pixel_x, rsp_pixel_y, rsp_pixel_colour, rsp_last_pixel);
            fault_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y
                  || rsp_pixel_colour !== want.colour || rsp_last_pixel !== want.is_end)
            begin
               if (fault_count < 10) begin
                  $write("pixel %0d mismatch: expected x=%0d y=%0d colour=%h last=%0d,",
                         pixels_checked, want.x, want.y, want.colour, want.is_end);
                  $display(" got x=%0d y=%0d colour=%h last=%0d",
                           rsp_pixel_x, rsp_pixel_y, rsp_pixel_colour, rsp_last_pixel);
               end
               fault_count++;
            end
            if (want.is_end) line_ends++;
            pixels_checked++;
         end
      end
   end

   initial begin
      int sx, sy, ex, ey, pix, span, kind;
      // Steps with no line loaded
      add_steps(2);
      // Zero-length line, then one step past its end
      add_word(OP_LOAD, 5, 5, 5, 5, 32'h0000_0000);
      add_steps(2);
      // Shallow line walking down both axes from the far corner
      add_word(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 1, 32'hFFFF_FFFF);
      add_steps(4);
      // Full-span diagonal, cut short by a steep line
      add_word(OP_LOAD, 0, COORD_MAX, COORD_MAX, 0, 32'hA5A5_5A5A);
      add_steps(2);
      add_word(OP_LOAD, 0, 0, 1, 3, 32'h1234_5678);
      add_steps(4);
      // Horizontal going left, then vertical going down the rows after a full drain
      add_word(OP_LOAD, COORD_MAX, 0, COORD_MAX - 1, 0, 32'h8000_0001);
      add_steps(2);
      add_word(OP_LOAD, 7, 0, 7, 2, 32'h7FFF_FFFE, 1'b1);
      add_steps(3);

      while (word_total < WORD_GOAL) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            sx = $urandom_range(COORD_MAX);
            sy = $urandom_range(COORD_MAX);
            span = ($urandom_range(9) == 0) ? 150 : 10;
            ex = near_coord(sx, span);
            ey = near_coord(sy, span);
            pix = ((ex > sx ? ex - sx : sx - ex) > (ey > sy ? ey - sy : sy - ey)
                   ? (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey)) + 1;
            add_word(OP_LOAD, sx, sy, ex, ey, $urandom(), $urandom_range(99) == 0);
            case ($urandom_range(9))
               0: add_steps($urandom_range(pix - 1));
               1: add_steps(pix + $urandom_range(1, 2));
               default: add_steps(pix);
            endcase
         end else if (kind < 90) begin
            add_word(OP_LOAD, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom());
            add_steps($urandom_range(1, 4));
         end else begin
            add_steps($urandom_range(1, 3));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("words sent: %0d including %0d line loads", words_sent, lines_loaded);
      $display("pixels checked: %0d, line ends seen: %0d, failures: %0d",
               pixels_checked, line_ends, fault_count);
      if (fault_count == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### midpoint_line_rasterizer_top.f
src/mlr_pkg.sv
src/mlr_step.sv
src/midpoint_line_rasterizer_top.sv
test/testbench.sv
